@@ rtl/chc_pkg.sv @@
// shared constants, command and status types and helper functions for the colour table
package chc_pkg;

    localparam int KEY_W           = 64;
    localparam int KEY_BYTES       = 8;
    localparam int COLOR_W         = 32;
    localparam int FUNC_W          = 2;
    localparam int CHARS_W         = 4;
    // only the low hash bits are ever used so HASH_W bits suffice
    localparam int HASH_W          = 12;
    localparam int BUCKET_BITS_DEF = 8;
    localparam int MAX_ENTRIES_DEF = 256;

    localparam logic [CHARS_W-1:0] CHARS_RESET = CHARS_W'(1);
    localparam logic [CHARS_W-1:0] CHARS_MAX   = CHARS_W'(KEY_BYTES);
    localparam logic [HASH_W-1:0]  HASH_MULT   = HASH_W'(33);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_LOOKUP = 2'd2
    } t_func;

    typedef struct packed {
        logic init_wr;
        logic accept;
        logic hash_step;
        logic clear_fill;
        logic head_rd;
        logic entry_rd_head;
        logic entry_rd_link;
        logic insert;
        logic set_hit;
        logic set_full;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic              init_done;
        logic [FUNC_W-1:0] func;
        logic              hash_last;
        logic              pool_full;
        logic              entry_ok;
        logic              key_match;
        logic              link_valid;
        logic              out_free;
    } t_stat;

    // characters per key clipped to the key width
    function automatic logic [CHARS_W-1:0] key_len(input logic [CHARS_W-1:0] chars);
        return (chars > CHARS_MAX) ? CHARS_MAX : chars;
    endfunction

    function automatic logic [KEY_W-1:0] len_mask(input logic [CHARS_W-1:0] n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (CHARS_W'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ rtl/chc_in_if.sv @@
// request channel: function code, key and colour
interface chc_in_if
    import chc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [COLOR_W-1:0] color;

    modport source (output valid, func, key, color, input ready);
    modport sink   (input valid, func, key, color, output ready);
endinterface

@@ rtl/chc_out_if.sv @@
// result channel: found colour, hit flag and status
interface chc_out_if
    import chc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] found_color;
    logic               found;
    logic               status;

    modport source (output valid, found_color, found, status, input ready);
    modport sink   (input valid, found_color, found, status, output ready);
endinterface

@@ rtl/chc_cfg_if.sv @@
// configuration write channel for the characters-per-key register
interface chc_cfg_if
    import chc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CHARS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/chc_ctrl.sv @@
// controller state machine sequencing hash, head read, chain walk and result
module chc_ctrl
    import chc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_ENTRY,
        S_CHECK,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.init_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                priority if (i_stat.func == FUNC_CLEAR) begin
                    o_cmd.clear_fill = 1'b1;
                    n_state          = S_RESULT;
                end else if (i_stat.func == FUNC_INSERT && i_stat.pool_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_RESULT;
                end else if (i_stat.func == FUNC_INSERT || i_stat.func == FUNC_LOOKUP) begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = S_ENTRY;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_ENTRY: begin
                o_cmd.entry_rd_head = 1'b1;
                n_state             = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_stat.func == FUNC_INSERT) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_RESULT;
                end else if (!i_stat.entry_ok) begin
                    n_state = S_RESULT;
                end else if (i_stat.key_match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_RESULT;
                end else if (i_stat.link_valid) begin
                    // next entry arrives next cycle, stay here
                    o_cmd.entry_rd_link = 1'b1;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

@@ rtl/chc_dp.sv @@
// datapath: key register, hash, bucket head and entry memories, result and output registers
module chc_dp
    import chc_pkg::*;
#(
    parameter int BUCKET_BITS = BUCKET_BITS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [COLOR_W-1:0] i_color,
    chc_cfg_if.sink            i_cfg,
    chc_out_if.source          o_out,
    input  t_cmd               i_cmd,
    output t_stat              o_stat
);

    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);
    // entry word: bucket | link valid | link index | colour | key
    localparam int COLOR_LSB   = KEY_W;
    localparam int LINK_LSB    = COLOR_LSB + COLOR_W;
    localparam int LVALID_BIT  = LINK_LSB + IDX_W;
    localparam int BUCKET_LSB  = LVALID_BIT + 1;
    localparam int ENTRY_W     = BUCKET_LSB + BUCKET_BITS;

    logic [IDX_W-1:0]   m_head  [NUM_BUCKETS];
    logic [ENTRY_W-1:0] m_entry [MAX_ENTRIES];

    logic [CHARS_W-1:0]     r_chars;
    logic [BUCKET_BITS-1:0] r_init_addr;
    logic [FILL_W-1:0]      r_fill;
    logic [FUNC_W-1:0]      r_func;
    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       r_mask;
    logic [COLOR_W-1:0]     r_color;
    logic [KEY_W-1:0]       r_hkey;
    logic [CHARS_W-1:0]     r_hleft;
    logic [HASH_W-1:0]      r_hash;
    logic [HASH_W-1:0]      n_hash;
    logic [IDX_W-1:0]       r_head_q;
    logic [ENTRY_W-1:0]     r_entry_q;
    logic [IDX_W-1:0]       r_cur;
    logic                   r_first;
    logic [COLOR_W-1:0]     r_res_color;
    logic                   r_res_found;
    logic                   r_res_status;
    logic                   r_out_valid;
    logic [COLOR_W-1:0]     r_out_color;
    logic                   r_out_found;
    logic                   r_out_status;

    logic [CHARS_W-1:0]     w_len;
    logic [BUCKET_BITS-1:0] w_bucket;
    logic [IDX_W-1:0]       w_entry_addr;
    logic                   w_head_ok;
    logic                   w_out_free;

    assign i_cfg.ready = 1'b1;

    assign w_len    = key_len(r_chars);
    assign w_bucket = r_hash[BUCKET_BITS-1:0];

    // two key bytes per cycle, h = h*33 + byte
    always_comb begin
        n_hash = r_hash;
        if (r_hleft != '0) begin
            n_hash = HASH_W'(n_hash * HASH_MULT) + HASH_W'(r_hkey[7:0]);
        end
        if (r_hleft > CHARS_W'(1)) begin
            n_hash = HASH_W'(n_hash * HASH_MULT) + HASH_W'(r_hkey[15:8]);
        end
    end

    assign w_entry_addr = i_cmd.entry_rd_head ? r_head_q
                                              : r_entry_q[LINK_LSB +: IDX_W];

    // a stale head from before a clear either points past the fill level or at an
    // entry that was linked into another bucket
    assign w_head_ok = (FILL_W'(r_cur) < r_fill)
                    && (r_entry_q[BUCKET_LSB +: BUCKET_BITS] == w_bucket);

    assign w_out_free = !r_out_valid || o_out.ready;

    assign o_stat.init_done  = (r_init_addr == BUCKET_BITS'(NUM_BUCKETS - 1));
    assign o_stat.func       = r_func;
    assign o_stat.hash_last  = (r_hleft <= CHARS_W'(2));
    assign o_stat.pool_full  = (r_fill == FILL_W'(MAX_ENTRIES));
    assign o_stat.entry_ok   = r_first ? w_head_ok : 1'b1;
    assign o_stat.key_match  = (((r_entry_q[KEY_W-1:0] ^ r_key) & r_mask) == '0);
    assign o_stat.link_valid = r_entry_q[LVALID_BIT];
    assign o_stat.out_free   = w_out_free;

    assign o_out.valid       = r_out_valid;
    assign o_out.found_color = r_out_color;
    assign o_out.found       = r_out_found;
    assign o_out.status      = r_out_status;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars     <= CHARS_RESET;
            r_init_addr <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_chars <= i_cfg.data;
            end
            if (i_cmd.init_wr) begin
                r_init_addr <= r_init_addr + BUCKET_BITS'(1);
            end
            if (i_cmd.clear_fill) begin
                r_fill <= '0;
            end else if (i_cmd.insert) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func       <= i_func;
            r_key        <= i_key;
            r_mask       <= len_mask(w_len);
            r_color      <= i_color;
            r_hkey       <= i_key;
            r_hleft      <= w_len;
            r_hash       <= '0;
            r_res_color  <= '0;
            r_res_found  <= 1'b0;
            r_res_status <= 1'b0;
        end
        if (i_cmd.hash_step) begin
            r_hkey  <= r_hkey >> 16;
            r_hleft <= (r_hleft > CHARS_W'(2)) ? r_hleft - CHARS_W'(2) : '0;
            r_hash  <= n_hash;
        end
        if (i_cmd.set_hit) begin
            r_res_color <= r_entry_q[COLOR_LSB +: COLOR_W];
            r_res_found <= 1'b1;
        end
        if (i_cmd.set_full) begin
            r_res_status <= 1'b1;
        end
        if (i_cmd.entry_rd_head || i_cmd.entry_rd_link) begin
            r_cur   <= w_entry_addr;
            r_first <= i_cmd.entry_rd_head;
        end
        if (i_cmd.push) begin
            r_out_color  <= r_res_color;
            r_out_found  <= r_res_found;
            r_out_status <= r_res_status;
        end
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_wr) begin
            m_head[r_init_addr] <= '0;
        end else if (i_cmd.insert) begin
            m_head[w_bucket] <= r_fill[IDX_W-1:0];
        end
        if (i_cmd.head_rd) begin
            r_head_q <= m_head[w_bucket];
        end
    end

    // entry memory, new entry links to the previous head of its bucket
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            m_entry[r_fill[IDX_W-1:0]] <= {w_bucket, w_head_ok, r_cur, r_color, r_key & r_mask};
        end
        if (i_cmd.entry_rd_head || i_cmd.entry_rd_link) begin
            r_entry_q <= m_entry[w_entry_addr];
        end
    end

endmodule

@@ rtl/chained_hash_color_table.sv @@
// chained hash colour table: maps keys of up to eight bytes to 32-bit colours
// i_in (valid/ready) carries func, key and color; func clear empties the table,
// insert links a new entry at the head of its bucket, lookup walks the chain.
// o_out (valid/ready) returns exactly one transaction per request: found_color
// and found for a lookup, status set when an insert finds the entry pool full.
// i_cfg writes chars_per_key (reset 1) and is always ready; it is to be written
// by the user only while no request is in flight; the block does not enforce it.
// the key is hashed two bytes per cycle; the chain walk of a lookup reads one
// entry per cycle. one request is worked on at a time; the next is taken as
// soon as its result sits in the output register, which holds it while
// o_out.ready is low. after reset the whole bucket head memory is swept before
// the first request is accepted; configuration writes are taken during the
// sweep.
module chained_hash_color_table
    import chc_pkg::*;
#(
    parameter int BUCKET_BITS = BUCKET_BITS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chc_in_if.sink    i_in,
    chc_out_if.source o_out,
    chc_cfg_if.sink   i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    chc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    chc_dp #(
        .BUCKET_BITS (BUCKET_BITS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_func  (i_in.func),
        .i_key   (i_in.key),
        .i_color (i_in.color),
        .i_cfg   (i_cfg),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule

@@ bench/chained_hash_color_table_test.sv @@
// self-checking testbench for the chained hash colour table: random requests, scoreboarded results
module chained_hash_color_table_test;
    import chc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBUCKETS = 1 << BUCKET_BITS_DEF;
    localparam int NENTRIES = MAX_ENTRIES_DEF;
    localparam int IDX_W    = $clog2(MAX_ENTRIES_DEF);
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // the limit covers the slowest legal run several times over; that run has full
    // chain walks at every lookup, 58% receiver stalls and the reset sweep
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int ITEM_TARGET  = 1950;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [COLOR_W-1:0] color;
    } t_request;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               hit;
        logic               dropped;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    chc_in_if  req_if ();
    chc_out_if rsp_if ();
    chc_cfg_if cfg_if ();

    chained_hash_color_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // table mirror
    logic [CHARS_W-1:0] chars_q;
    logic               head_v [NBUCKETS];
    logic [IDX_W-1:0]   head_i [NBUCKETS];
    logic [KEY_W-1:0]   ent_key [NENTRIES];
    logic [COLOR_W-1:0] ent_col [NENTRIES];
    logic               link_v [NENTRIES];
    logic [IDX_W-1:0]   link_i [NENTRIES];
    logic [IDX_W:0]     fill_q;

    t_request pending_reqs[$];
    t_answer  answers_due[$];
    int       n_sent = 0;
    int       n_made;
    int       n_fail = 0;
    int       cycles = 0;
    logic     rsp_hold;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int eff_len(input logic [CHARS_W-1:0] c);
        return (c > 4'd8) ? 8 : int'(c);
    endfunction

    function automatic logic [KEY_W-1:0] byte_mask(input int n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic int bucket_hash(input logic [KEY_W-1:0] key, input int n);
        logic [31:0] h;
        h = '0;
        for (int i = 0; i < n; i++) begin
            h = h * 32'd33 + {24'd0, key[8*i +: 8]};
        end
        return int'(h & (NBUCKETS - 1));
    endfunction

    // applies one request to the mirror and returns the answer it should produce
    function automatic t_answer table_step(input logic [FUNC_W-1:0] f,
                                           input logic [KEY_W-1:0] key,
                                           input logic [COLOR_W-1:0] col);
        t_answer          a;
        int               n;
        int               b;
        int               steps;
        logic [KEY_W-1:0] m;
        logic             vld;
        logic             done;
        logic [IDX_W-1:0] cur;
        a = '0;
        n = eff_len(chars_q);
        m = byte_mask(n);
        case (f)
            FUNC_CLEAR: begin
                for (int i = 0; i < NBUCKETS; i++) head_v[i] = 1'b0;
                fill_q = '0;
            end
            FUNC_INSERT: begin
                if (fill_q >= NENTRIES) begin
                    a.dropped = 1'b1;
                end else begin
                    b = bucket_hash(key, n);
                    ent_key[fill_q[IDX_W-1:0]] = key & m;
                    ent_col[fill_q[IDX_W-1:0]] = col;
                    link_v[fill_q[IDX_W-1:0]]  = head_v[b];
                    link_i[fill_q[IDX_W-1:0]]  = head_i[b];
                    head_v[b]                  = 1'b1;
                    head_i[b]                  = fill_q[IDX_W-1:0];
                    fill_q                     = fill_q + 1'b1;
                end
            end
            FUNC_LOOKUP: begin
                b     = bucket_hash(key, n);
                vld   = head_v[b];
                cur   = head_i[b];
                steps = 0;
                done  = 1'b0;
                while (vld && !done && steps < NENTRIES) begin
                    if (((ent_key[cur] ^ key) & m) == '0) begin
                        a.color = ent_col[cur];
                        a.hit   = 1'b1;
                        done    = 1'b1;
                    end else begin
                        vld = link_v[cur];
                        cur = link_i[cur];
                        steps++;
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic int send_idle_pct();
        return (n_sent < 650) ? 8 : ((n_sent < 1300) ? 58 : 0);
    endfunction

    function automatic int recv_idle_pct();
        return (n_sent < 650) ? 58 : ((n_sent < 1300) ? 8 : 0);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                answers_due.push_back(table_step(req_if.func, req_if.key, req_if.color));
                n_sent <= n_sent + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
                    nxt = pending_reqs.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.func  <= nxt.func;
                    req_if.key   <= nxt.key;
                    req_if.color <= nxt.color;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and scoreboard
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (answers_due.size() == 0) begin
                    $error("result transaction with nothing outstanding");
                    n_fail++;
                end else begin
                    want = answers_due.pop_front();
                    if (rsp_if.found_color !== want.color) begin
                        $error("found_color: expected %h, got %h", want.color,
                               rsp_if.found_color);
                        n_fail++;
                    end
                    if (rsp_if.found !== want.hit) begin
                        $error("found: expected %b, got %b", want.hit, rsp_if.found);
                        n_fail++;
                    end
                    if (rsp_if.status !== want.dropped) begin
                        $error("status: expected %b, got %b", want.dropped, rsp_if.status);
                        n_fail++;
                    end
                end
            end
            rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // long receiver stall while the queue still has plenty to offer
    initial begin
        rsp_hold = 1'b0;
        do @(negedge i_clk); while (!(n_sent >= 300 && pending_reqs.size() > 40));
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // random key whose first n bytes hash to the given bucket when n is above zero
    function automatic logic [KEY_W-1:0] colliding_key(input int tgt, input int n);
        logic [KEY_W-1:0] k;
        logic [7:0]       h;
        k = rand_key();
        if (n > 0) begin
            h = '0;
            for (int i = 0; i < n - 1; i++) h = h * 8'd33 + k[8*i +: 8];
            k[8*(n-1) +: 8] = 8'(tgt) - h * 8'd33;
        end
        return k;
    endfunction

    function automatic void add_req(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                                    input logic [COLOR_W-1:0] c);
        t_request r;
        r.func  = f;
        r.key   = k;
        r.color = c;
        pending_reqs.push_back(r);
        n_made++;
    endfunction

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || answers_due.size() != 0);
    endtask

    task automatic write_chars(input logic [CHARS_W-1:0] v);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        chars_q = v;
        @(negedge i_clk);
    endtask

    function automatic logic [CHARS_W-1:0] pick_chars();
        case ($urandom_range(9))
            0: return 4'd0;
            1: return 4'd1;
            2: return 4'd8;
            3: return 4'd15;
            4: return CHARS_W'($urandom_range(14, 9));
            default: return CHARS_W'($urandom_range(7, 2));
        endcase
    endfunction

    initial begin : stimulus
        logic [KEY_W-1:0] ks[$];
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] m;
        int               n;
        int               cnt;
        int               r;
        int               tgt;

        i_rst_n      <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= CHARS_RESET;
        chars_q = CHARS_RESET;
        for (int i = 0; i < NBUCKETS; i++) begin
            head_v[i] = 1'b0;
            head_i[i] = '0;
        end
        fill_q = '0;
        n_made = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: one key byte from reset, empty table, duplicates, ignored upper bytes
        add_req(FUNC_CLEAR, '0, '0);
        add_req(FUNC_LOOKUP, '0, '0);
        add_req(FUNC_INSERT, '0, '0);
        add_req(FUNC_INSERT, '1, '1);
        add_req(FUNC_LOOKUP, '0, '1);
        add_req(FUNC_LOOKUP, '1, '0);
        add_req(FUNC_INSERT, 64'hAAAA_5555_0000_0000, 32'h1234_5678);
        add_req(FUNC_LOOKUP, 64'h0000_0000_00FF_FF00, '0);
        add_req(FUNC_LOOKUP, 64'h1, '0);
        add_req(FUNC_UNUSED, '1, '1);
        add_req(FUNC_CLEAR, '1, '1);
        add_req(FUNC_LOOKUP, '1, '0);
        wait_quiet();
        // zero length key: everything lands in bucket 0 and matches the head
        write_chars(4'd0);
        add_req(FUNC_INSERT, 64'h0123_4567_89AB_CDEF, 32'h0BAD_F00D);
        add_req(FUNC_LOOKUP, 64'hFEDC_BA98_7654_3210, '0);
        wait_quiet();
        // length above eight behaves as eight
        write_chars(4'd15);
        add_req(FUNC_CLEAR, '0, '0);
        add_req(FUNC_INSERT, '1, 32'h8000_0001);
        add_req(FUNC_LOOKUP, '1, '0);
        add_req(FUNC_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        add_req(FUNC_INSERT, 64'h8000_0000_0000_0000, 32'h1);
        add_req(FUNC_LOOKUP, 64'h8000_0000_0000_0000, '0);
        wait_quiet();
        write_chars(4'd8);
        add_req(FUNC_UNUSED, '0, '0);

        while (n_made < ITEM_TARGET) begin
            wait_quiet();
            write_chars(pick_chars());
            n = eff_len(chars_q);
            m = byte_mask(n);
            r = $urandom_range(7);
            if (r == 0) begin
                // run the pool past full
                ks.delete();
                add_req(FUNC_CLEAR, rand_key(), $urandom);
                cnt = NENTRIES + $urandom_range(20, 4);
                for (int i = 0; i < cnt; i++) begin
                    k = rand_key();
                    ks.push_back(k);
                    add_req(FUNC_INSERT, k, $urandom);
                    if ($urandom_range(3) == 0) begin
                        add_req(FUNC_LOOKUP, ks[$urandom_range(ks.size() - 1)], $urandom);
                    end
                end
                add_req(FUNC_LOOKUP, ks[0], $urandom);
            end else if (r == 1) begin
                // one bucket, long chain, lookups reaching deep
                ks.delete();
                add_req(FUNC_CLEAR, rand_key(), $urandom);
                tgt = $urandom_range(NBUCKETS - 1);
                cnt = $urandom_range(60, 20);
                for (int i = 0; i < cnt; i++) begin
                    k = colliding_key(tgt, n);
                    ks.push_back(k);
                    add_req(FUNC_INSERT, k, $urandom);
                end
                for (int i = 0; i < cnt; i++) begin
                    if ($urandom_range(4) == 0) begin
                        add_req(FUNC_LOOKUP, colliding_key(tgt, n), $urandom);
                    end else begin
                        k = ks[$urandom_range(ks.size() - 1)];
                        add_req(FUNC_LOOKUP, k ^ (rand_key() & ~m), $urandom);
                    end
                end
            end else begin
                if ($urandom_range(4) != 0) begin
                    ks.delete();
                    add_req(FUNC_CLEAR, rand_key(), $urandom);
                end
                cnt = $urandom_range(90, 20);
                for (int i = 0; i < cnt; i++) begin
                    r = $urandom_range(99);
                    if (r < 40) begin
                        if (ks.size() > 0 && $urandom_range(3) == 0) begin
                            // newer duplicate of a stored key
                            k = ks[$urandom_range(ks.size() - 1)] ^ (rand_key() & ~m);
                        end else begin
                            k = rand_key();
                        end
                        ks.push_back(k);
                        add_req(FUNC_INSERT, k, $urandom);
                    end else if (r < 85 && ks.size() > 0) begin
                        k = ks[$urandom_range(ks.size() - 1)];
                        add_req(FUNC_LOOKUP, k ^ (rand_key() & ~m), $urandom);
                    end else if (r < 97) begin
                        add_req(FUNC_LOOKUP, rand_key(), $urandom);
                    end else if (r < 99) begin
                        add_req(FUNC_UNUSED, rand_key(), $urandom);
                    end else begin
                        ks.delete();
                        add_req(FUNC_CLEAR, rand_key(), $urandom);
                    end
                end
            end
        end

        wait_quiet();
        // let any stray transaction show up before the verdict
        repeat (40) @(posedge i_clk);
        if (n_fail == 0 && answers_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
